/* sv/zss_pkg.sv */
`default_nettype none

package zss_pkg;

  // result field width
  localparam int COUNT_W = 20;

  // defaults for the top-level parameters
  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int TABLE_DEPTH_DEF = 2048;
  localparam int VALUE_WIDTH_DEF = 32;

  // per-array generation tag kept with every table entry
  localparam int EPOCH_W = 8;

  // hash mixing constant
  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

endpackage

`default_nettype wire

/* sv/zero_sum_subarray_counter.sv */
`default_nettype none

// Counts zero-sum subarrays of a signed array streamed in one element per
// transaction, with in_last on the final element. Each element returns one
// transaction carrying the running count; the one for the last element has
// out_last_res set and the count is final. An array with more than MAX_ITEMS
// elements raises out_too_long and the count holds until the array ends.
// Prefix sums are counted in a linear-probing hash table in one simple
// dual-port RAM of TABLE_DEPTH words, each tagged with an array generation
// number. Each element is hashed, then the table is probed; each probe is a
// RAM read then a compare/write-back. When TABLE_DEPTH is not a power of two
// the hash is reduced by folding and a reciprocal multiply; the hash runs on
// one shared 32x32 multiplier. Elements beyond MAX_ITEMS skip the hash and
// the table. The block takes one element at a time; the output register lets
// it take the next element while a result waits. After the last element the
// table is reseeded; after reset, and once every 255 arrays, a sweep clears
// the table and in_stall stays high meanwhile.

module zero_sum_subarray_counter #(
  parameter int MAX_ITEMS   = zss_pkg::MAX_ITEMS_DEF,
  parameter int TABLE_DEPTH = zss_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = zss_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [31:0]                  in_value,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [zss_pkg::COUNT_W-1:0]       out_zero_sum_count,
  output logic                              out_last_res,
  output logic                              out_too_long
);

  import zss_pkg::*;

  localparam int SUM_W  = VALUE_WIDTH + $clog2(MAX_ITEMS);
  localparam int IDX_W  = $clog2(MAX_ITEMS + 1);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 2);
  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int WORD_W = EPOCH_W + SUM_W + CNT_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_SEED  = 3'd1;
  localparam logic [2:0] ST_IDLE  = 3'd2;
  localparam logic [2:0] ST_HASH  = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_CHK   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               ovf_r, ovf_nxt;
  logic               last_r, last_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      probes_r, probes_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_long_r, out_long_nxt;

  logic                          in_xact;
  logic                          out_free;
  logic signed [VALUE_WIDTH-1:0] v_s;
  logic [SUM_W-1:0]              v_ext;
  logic [SUM_W-1:0]              sum_add;

  logic                hash_start;
  logic                hash_done;
  logic [AW-1:0]       hash_pos;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [WORD_W-1:0]   wdata;
  logic [WORD_W-1:0]   rdata;
  logic [EPOCH_W-1:0]  rd_epoch;
  logic [SUM_W-1:0]    rd_key;
  logic [CNT_W-1:0]    rd_cnt;
  logic [AW-1:0]       pos_inc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xact  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // low VALUE_WIDTH bits of the element, sign-extended to the sum width
  assign v_s     = VALUE_WIDTH'({{VALUE_WIDTH{1'b0}}, in_value});
  assign v_ext   = SUM_W'(v_s);
  assign sum_add = sum_r + v_ext;

  // table word fields
  assign rd_epoch = rdata[WORD_W-1 -: EPOCH_W];
  assign rd_key   = rdata[CNT_W +: SUM_W];
  assign rd_cnt   = rdata[CNT_W-1:0];

  assign pos_inc = (pos_r == AW'(TABLE_DEPTH - 1)) ? '0 : pos_r + AW'(1);

  zss_hash #(
    .SUM_W       (SUM_W),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (sum_add),
    .done  (hash_done),
    .pos   (hash_pos)
  );

  zss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pos_r),
    .rdata (rdata)
  );

  // main sequencer
  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    clr_nxt       = clr_r;
    sum_nxt       = sum_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    probes_nxt    = probes_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    out_long_nxt  = out_long_r;
    hash_start    = 1'b0;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = {epoch_r, sum_r, CNT_W'(1)};
    unique case (state_r)
      // wipe every entry to the never-used generation
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          epoch_nxt = EPOCH_W'(1);
          state_nxt = ST_SEED;
        end
      end
      // prefix sum zero seen once; zero hashes to slot zero
      ST_SEED: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = {epoch_r, {SUM_W{1'b0}}, CNT_W'(1)};
        state_nxt = ST_IDLE;
      end
      // take an element
      ST_IDLE: begin
        if (in_xact) begin
          last_nxt = in_last;
          if (ovf_r) begin
            state_nxt = ST_DONE;
          end else if (idx_r >= IDX_W'(MAX_ITEMS)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt    = idx_r + IDX_W'(1);
            sum_nxt    = sum_add;
            hash_start = 1'b1;
            state_nxt  = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          pos_nxt    = hash_pos;
          probes_nxt = '0;
          state_nxt  = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      // compare the probed slot and write back
      ST_CHK: begin
        if (rd_epoch != epoch_r) begin
          we        = 1'b1;
          state_nxt = ST_DONE;
        end else if (rd_key == sum_r) begin
          we        = 1'b1;
          wdata     = {epoch_r, sum_r, rd_cnt + CNT_W'(1)};
          total_nxt = total_r + COUNT_W'(rd_cnt);
          state_nxt = ST_DONE;
        end else if (probes_r == AW'(TABLE_DEPTH - 1)) begin
          // table full: counts as never seen, not stored
          state_nxt = ST_DONE;
        end else begin
          pos_nxt    = pos_inc;
          probes_nxt = probes_r + AW'(1);
          state_nxt  = ST_RD;
        end
      end
      // hand the result to the output register, then reset after the last one
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = total_r;
          out_last_nxt  = last_r;
          out_long_nxt  = ovf_r;
          state_nxt     = ST_IDLE;
          if (last_r) begin
            sum_nxt   = '0;
            total_nxt = '0;
            idx_nxt   = '0;
            ovf_nxt   = 1'b0;
            if (epoch_r == {EPOCH_W{1'b1}}) begin
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
              state_nxt = ST_SEED;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      epoch_r     <= '0;
      clr_r       <= '0;
      sum_r       <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      clr_r       <= clr_nxt;
      sum_r       <= sum_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    pos_r       <= pos_nxt;
    probes_r    <= probes_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
    out_long_r  <= out_long_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_zero_sum_count = out_count_r;
  assign out_last_res       = out_last_r;
  assign out_too_long       = out_long_r;

  // checks
  a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (idx_r == IDX_W'(MAX_ITEMS)))
    else $error("overflow flag set before the element limit");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |-> (epoch_r != '0))
    else $error("live generation tag equals the cleared tag");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done step");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact |=> (state_r == ST_HASH || state_r == ST_DONE))
    else $error("accepted transaction not taken up");

endmodule

`default_nettype wire

/* sv/zss_ram.sv */
`default_nettype none

module zss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/zss_hash.sv */
`default_nettype none

module zss_hash #(
  parameter int SUM_W       = 42,
  parameter int TABLE_DEPTH = 2048
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [SUM_W-1:0]               key,
  output logic                                done,
  output logic [$clog2(TABLE_DEPTH)-1:0]      pos
);

  import zss_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam bit DEPTH_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  // reduction constants: 2^32 = RECIP * TABLE_DEPTH + FOLD_C
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
  localparam logic [31:0] FOLD_C  = 32'((64'd1 << 32) % 64'(TABLE_DEPTH));
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(TABLE_DEPTH));

  localparam logic [3:0] H_IDLE = 4'd0;
  localparam logic [3:0] H_M0   = 4'd1;
  localparam logic [3:0] H_M1   = 4'd2;
  localparam logic [3:0] H_M2   = 4'd3;
  localparam logic [3:0] H_MIX  = 4'd4;
  localparam logic [3:0] H_FOLD = 4'd5;
  localparam logic [3:0] H_QUO  = 4'd6;
  localparam logic [3:0] H_REM  = 4'd7;
  localparam logic [3:0] H_FIX  = 4'd8;

  logic [3:0]    hs_r, hs_nxt;
  logic [63:0]   x_r, x_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [63:0]   h_r, h_nxt;
  logic          done_r, done_nxt;
  logic [AW-1:0] pos_r, pos_nxt;

  logic [63:0] key64;
  logic [63:0] x_mix;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] h_mix;
  logic [31:0] fix_sub;

  // fold the sign-extended key onto itself
  assign key64 = 64'($signed(key));
  assign x_mix = key64 ^ (key64 >> 21) ^ (key64 >> 42);

  // shared 32x32 multiplier, operands picked per step
  always_comb begin
    unique case (hs_r)
      H_M1:    begin mul_a = x_r[31:0];   mul_b = HASH_MULT[63:32]; end
      H_M2:    begin mul_a = x_r[63:32];  mul_b = HASH_MULT[31:0];  end
      H_FOLD:  begin mul_a = h_r[63:32];  mul_b = FOLD_C;           end
      H_QUO:   begin mul_a = h_r[31:0];   mul_b = RECIP;            end
      H_REM:   begin mul_a = acc_r[31:0]; mul_b = DEPTH32;          end
      default: begin mul_a = x_r[31:0];   mul_b = HASH_MULT[31:0];  end
    endcase
  end

  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign h_mix   = acc_r ^ (acc_r >> 29);
  assign fix_sub = acc_r[31:0] - DEPTH32;

  // hash sequencer
  always_comb begin
    hs_nxt   = hs_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    h_nxt    = h_r;
    done_nxt = 1'b0;
    pos_nxt  = pos_r;
    unique case (hs_r)
      H_IDLE: begin
        if (start) begin
          x_nxt  = x_mix;
          hs_nxt = H_M0;
        end
      end
      H_M0: begin
        acc_nxt = prod;
        hs_nxt  = H_M1;
      end
      H_M1: begin
        acc_nxt = acc_r + {prod[31:0], 32'd0};
        hs_nxt  = H_M2;
      end
      H_M2: begin
        acc_nxt = acc_r + {prod[31:0], 32'd0};
        hs_nxt  = H_MIX;
      end
      H_MIX: begin
        if (DEPTH_POW2) begin
          pos_nxt  = h_mix[AW-1:0];
          done_nxt = 1'b1;
          hs_nxt   = H_IDLE;
        end else begin
          h_nxt  = h_mix;
          hs_nxt = H_FOLD;
        end
      end
      // fold the upper half back in until the value fits in 32 bits
      H_FOLD: begin
        if (h_r[63:32] == 32'd0) begin
          hs_nxt = H_QUO;
        end else begin
          h_nxt = prod + {32'd0, h_r[31:0]};
        end
      end
      // quotient estimate, low by at most one
      H_QUO: begin
        acc_nxt = {32'd0, prod[63:32]};
        hs_nxt  = H_REM;
      end
      H_REM: begin
        acc_nxt = {32'd0, h_r[31:0] - prod[31:0]};
        hs_nxt  = H_FIX;
      end
      // one correcting subtract
      H_FIX: begin
        if (acc_r[31:0] >= DEPTH32) begin
          pos_nxt = fix_sub[AW-1:0];
        end else begin
          pos_nxt = acc_r[AW-1:0];
        end
        done_nxt = 1'b1;
        hs_nxt   = H_IDLE;
      end
      default: begin
        hs_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r   <= H_IDLE;
      done_r <= 1'b0;
    end else begin
      hs_r   <= hs_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    h_r   <= h_nxt;
    pos_r <= pos_nxt;
  end

  assign done = done_r;
  assign pos  = pos_r;

endmodule

`default_nettype wire

/* tb/zero_sum_subarray_counter_tb.sv */
`timescale 1ns / 1ps

module zero_sum_subarray_counter_tb;
  import zss_pkg::*;

  localparam int MAX_ELEMS = MAX_ITEMS_DEF;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam longint VAL_MAX = 64'sd2147483647;

  // stimulus shape and pacing
  localparam int SHORT_ARRAYS = 130;
  localparam int LONG_LEN     = MAX_ELEMS + 4;
  localparam int PHASE1_AT    = 520;
  localparam int PHASE2_AT    = 1040;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_AT     = 420;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_CAP    = 30;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } element_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               last_res;
    logic               too_long;
  } count_result_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [31:0]        in_value  = '0;
  logic               in_last   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] out_zero_sum_count;
  logic               out_last_res;
  logic               out_too_long;

  zero_sum_subarray_counter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_zero_sum_count (out_zero_sum_count),
    .out_last_res       (out_last_res),
    .out_too_long       (out_too_long)
  );

  // pending elements and expected counts
  element_t      pending_elems[$];
  count_result_t expected_counts[$];
  element_t      next_elem;

  int  total_elems = 0;
  int  n_sent      = 0;
  int  n_checked   = 0;
  int  n_errors    = 0;
  int  cycle_count = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  bit  drain_done  = 1'b0;

  // running prefix sum of the stimulus builder, used to aim at zero sums
  longint build_sum = 0;

  // prefix-sum counter state
  longint      pred_sum;
  int unsigned zero_total;
  int          elem_seen;
  bit          past_limit;
  int          prefix_hits[longint];

  function automatic void clear_prefix_table();
    pred_sum   = 0;
    zero_total = 0;
    elem_seen  = 0;
    past_limit = 1'b0;
    prefix_hits.delete();
    prefix_hits[0] = 1;
  endfunction

  function automatic count_result_t predict_count(logic [31:0] value, logic last);
    count_result_t r;
    if (!past_limit) begin
      if (elem_seen >= MAX_ELEMS) begin
        past_limit = 1'b1;
      end else begin
        elem_seen++;
        pred_sum += longint'($signed(value));
        if (prefix_hits.exists(pred_sum)) begin
          zero_total += prefix_hits[pred_sum];
          prefix_hits[pred_sum]++;
        end else begin
          prefix_hits[pred_sum] = 1;
        end
      end
    end
    r.count    = zero_total[COUNT_W-1:0];
    r.last_res = last;
    r.too_long = past_limit;
    if (last) clear_prefix_table();
    return r;
  endfunction

  task automatic add_element(logic [31:0] value, logic last);
    element_t e;
    e.value = value;
    e.last  = last;
    pending_elems.push_back(e);
    build_sum = last ? 0 : build_sum + longint'($signed(value));
    total_elems++;
  endtask

  // mix of zero-closing, zero, small, extreme and full-range values
  function automatic logic [31:0] pick_value();
    int     kind;
    longint neg;
    kind = $urandom_range(9, 0);
    neg  = -build_sum;
    if (kind < 3 && neg >= VAL_MIN && neg <= VAL_MAX) return neg[31:0];
    if (kind < 5) return '0;
    if (kind < 7) return $urandom_range(6, 0) - 32'd3;
    if (kind == 7) return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom();
  endfunction

  task automatic add_short_arrays(int n_arrays);
    int len;
    for (int a = 0; a < n_arrays; a++) begin
      len = $urandom_range(3, 1);
      for (int i = 0; i < len; i++) add_element(pick_value(), i == len - 1);
    end
  endtask

  task automatic report_mismatch(string what, longint exp_val, longint got_val);
    if (n_errors < PRINT_CAP)
      $display("mismatch at result %0d: %s expected %0d got %0d",
               n_checked, what, exp_val, got_val);
    n_errors++;
  endtask

  function automatic int sender_idle_pct();
    if (n_sent < PHASE1_AT) return 27;
    if (n_sent < PHASE2_AT) return 76;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_sent < PHASE1_AT) return 76;
    if (n_sent < PHASE2_AT) return 27;
    return 0;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("zero_sum_subarray_counter_tb: FAIL");
      $finish;
    end
  end

  // driver: offers pending elements, predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
      in_last  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_counts.push_back(predict_count(in_value, in_last));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        // one pause until every expected count has come back
        if (!drain_done && n_sent >= DRAIN_AT && expected_counts.size() == 0)
          drain_done = 1'b1;
        if (pending_elems.size() > 0 && (drain_done || n_sent < DRAIN_AT) &&
            $urandom_range(99, 0) >= sender_idle_pct()) begin
          next_elem = pending_elems.pop_front();
          in_valid <= 1'b1;
          in_value <= next_elem.value;
          in_last  <= next_elem.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result transaction with the oldest expected count
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("unexpected transaction, count", -64'sd1,
                          longint'(out_zero_sum_count));
        end else begin
          if (out_zero_sum_count !== expected_counts[0].count)
            report_mismatch("zero_sum_count", longint'(expected_counts[0].count),
                            longint'(out_zero_sum_count));
          if (out_last_res !== expected_counts[0].last_res)
            report_mismatch("last_res", longint'(expected_counts[0].last_res),
                            longint'(out_last_res));
          if (out_too_long !== expected_counts[0].too_long)
            report_mismatch("too_long", longint'(expected_counts[0].too_long),
                            longint'(out_too_long));
          void'(expected_counts.pop_front());
        end
        n_checked++;
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < receiver_idle_pct());
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    clear_prefix_table();

    // single elements: zero, most positive, most negative
    add_element(32'd0, 1'b1);
    add_element(32'h7FFF_FFFF, 1'b1);
    add_element(32'h8000_0000, 1'b1);
    // simple cancelling pair
    add_element(32'd5, 1'b0);
    add_element(32'hFFFF_FFFB, 1'b1);
    // all zeros
    add_element(32'd0, 1'b0);
    add_element(32'd0, 1'b0);
    add_element(32'd0, 1'b1);
    // prefix sum wraps in 32 bits but not in full width
    add_element(32'h8000_0000, 1'b0);
    add_element(32'h8000_0000, 1'b1);
    // far excursion returning to zero
    add_element(32'h8000_0000, 1'b0);
    add_element(32'h8000_0000, 1'b0);
    add_element(32'h7FFF_FFFF, 1'b0);
    add_element(32'h7FFF_FFFF, 1'b0);
    add_element(32'd2, 1'b1);
    // alternating signs
    add_element(32'd1, 1'b0);
    add_element(32'hFFFF_FFFF, 1'b0);
    add_element(32'd1, 1'b0);
    add_element(32'hFFFF_FFFF, 1'b1);
    // alternating bit patterns
    add_element(32'h5555_5555, 1'b0);
    add_element(32'hAAAA_AAAA, 1'b0);
    add_element(32'd1, 1'b1);

    // short arrays, one array past the element limit, more short arrays
    add_short_arrays(SHORT_ARRAYS);
    for (int i = 0; i < LONG_LEN; i++) add_element(pick_value(), i == LONG_LEN - 1);
    add_short_arrays(SHORT_ARRAYS);

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent < total_elems) @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_counts.size() != 0)
      report_mismatch("results still missing", 64'sd0, longint'(expected_counts.size()));
    if (n_errors == 0) begin
      $display("zero_sum_subarray_counter_tb: PASS");
    end else begin
      $display("zero_sum_subarray_counter_tb: FAIL");
    end
    $finish;
  end

endmodule
